>>> design/rdcp_pkg.sv
// Shared types, constants and helpers for the random draw code pool.
package rdcp_pkg;

  // Number of four-digit codes and the width of every code, index and count.
  localparam int CODE_COUNT = 10000;
  localparam int FIELD_W    = 14;
  localparam int DIGIT_W    = 4;
  localparam int RADIX      = 10;

  localparam logic [FIELD_W-1:0] LAST_CODE = FIELD_W'(CODE_COUNT - 1);
  localparam logic [FIELD_W-1:0] POOL_MAX  = FIELD_W'(CODE_COUNT);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(RADIX - 1);

  // Result status codes.
  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef logic [FIELD_W-1:0] field_t;
  typedef logic [DIGIT_W-1:0] digit_t;

  // What the refill scanner presents for the current code.
  typedef struct packed {
    field_t code;
    logic   keep;
    logic   last;
  } scan_t;

  // Cyclic step (a - b) mod 10 between two decimal digits.
  function automatic digit_t digit_step(input digit_t a, input digit_t b);
    logic [DIGIT_W:0] t;
    t = {1'b0, a} + (DIGIT_W + 1)'(RADIX) - {1'b0, b};
    if (t >= (DIGIT_W + 1)'(RADIX)) begin
      t = t - (DIGIT_W + 1)'(RADIX);
    end
    return t[DIGIT_W-1:0];
  endfunction

endpackage

>>> design/rdcp_in_if.sv
// Request channel carrying the random index of one draw.
interface rdcp_in_if;
  logic                    valid;
  logic                    ready;
  logic [rdcp_pkg::FIELD_W-1:0] random_index;

  modport source (output valid, output random_index, input ready);
  modport sink   (input valid, input random_index, output ready);
endinterface

>>> design/rdcp_out_if.sv
// Result channel carrying the drawn code, the pool count and the status.
interface rdcp_out_if;
  logic                    valid;
  logic                    ready;
  logic [rdcp_pkg::FIELD_W-1:0] drawn_code;
  logic [rdcp_pkg::FIELD_W-1:0] remaining;
  logic                    status;

  modport source (output valid, output drawn_code, output remaining, output status,
                  input ready);
  modport sink   (input valid, input drawn_code, input remaining, input status,
                  output ready);
endinterface

>>> design/rdcp_refill_scan.sv
// Refill scanner: walks the codes in order and flags the ones to keep.
module rdcp_refill_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            clr,
  input  logic            adv,
  input  logic            filter,
  output rdcp_pkg::scan_t scan
);

  rdcp_pkg::field_t code_r, code_nxt;
  rdcp_pkg::digit_t d0_r, d1_r, d2_r, d3_r;
  rdcp_pkg::digit_t d0_nxt, d1_nxt, d2_nxt, d3_nxt;
  rdcp_pkg::digit_t s0, s1, s2;
  logic             run;

  // Decimal digits count alongside the binary code, so no division is needed.
  always_comb begin
    code_nxt = code_r + rdcp_pkg::field_t'(1);
    d0_nxt   = d0_r;
    d1_nxt   = d1_r;
    d2_nxt   = d2_r;
    d3_nxt   = d3_r;
    if (d0_r != rdcp_pkg::DIGIT_MAX) begin
      d0_nxt = d0_r + rdcp_pkg::digit_t'(1);
    end else begin
      d0_nxt = '0;
      if (d1_r != rdcp_pkg::DIGIT_MAX) begin
        d1_nxt = d1_r + rdcp_pkg::digit_t'(1);
      end else begin
        d1_nxt = '0;
        if (d2_r != rdcp_pkg::DIGIT_MAX) begin
          d2_nxt = d2_r + rdcp_pkg::digit_t'(1);
        end else begin
          d2_nxt = '0;
          d3_nxt = d3_r + rdcp_pkg::digit_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      code_r <= '0;
      d0_r   <= '0;
      d1_r   <= '0;
      d2_r   <= '0;
      d3_r   <= '0;
    end else if (adv) begin
      code_r <= code_nxt;
      d0_r   <= d0_nxt;
      d1_r   <= d1_nxt;
      d2_r   <= d2_nxt;
      d3_r   <= d3_nxt;
    end
  end

  // A code is an arithmetic run when all three cyclic digit steps match.
  assign s0  = rdcp_pkg::digit_step(d0_r, d1_r);
  assign s1  = rdcp_pkg::digit_step(d1_r, d2_r);
  assign s2  = rdcp_pkg::digit_step(d2_r, d3_r);
  assign run = (s0 == s1) && (s1 == s2);

  assign scan.code = code_r;
  assign scan.keep = !filter || !run;
  assign scan.last = (code_r == rdcp_pkg::LAST_CODE);

endmodule

>>> design/random_draw_code_pool.sv
// Random draw code pool: hands out four-digit codes without replacement.
//
// The request channel in_ch carries a random index into the live pool; the
// result channel out_ch returns one word per request: the drawn code, the
// count left in the pool and a status bit. An index not below the count
// gives status 1, code 0 and leaves the pool untouched.
// The pool sits in one 10000-entry memory with two read ports and one write
// port. A draw reads the chosen entry and the last live entry, then writes the
// last entry into the hole and loads the result. A request that finds the pool
// empty first runs a refill that walks all 10000 codes, one code per cycle,
// writing kept ones through the write port, then the draw. After reset the
// same refill runs, with in_ch.ready low until it ends. The value of cfg_wdata
// written on cfg_we selects whether the refill drops arithmetic runs; it is
// sampled when a refill starts. The result sits in an output register, so a
// new request is taken while a result waits; when the receiver stalls, the
// following draw holds its read data until the register frees up.
module random_draw_code_pool (
  input  logic              clk,
  input  logic              rst_n,
  rdcp_in_if.sink           in_ch,
  rdcp_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  typedef enum logic [3:0] {
    S_REFILL = 4'b0001,
    S_IDLE   = 4'b0010,
    S_ISSUE  = 4'b0100,
    S_DRAW   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic             reject_r;
  logic             filter_r;
  logic             pending_r;
  rdcp_pkg::field_t count_r;
  rdcp_pkg::field_t fill_r;
  rdcp_pkg::field_t idx_r;
  logic             err_r;

  logic             out_valid_r;
  rdcp_pkg::field_t out_code_r;
  rdcp_pkg::field_t out_remaining_r;
  logic             out_status_r;

  rdcp_pkg::field_t mem [rdcp_pkg::CODE_COUNT];
  rdcp_pkg::field_t rd_a_q, rd_b_q;
  rdcp_pkg::field_t rd_a_addr, rd_b_addr, wr_addr, wr_data;
  logic             rd_a_en, rd_b_en, wr_en;

  rdcp_pkg::scan_t  scan;
  rdcp_pkg::field_t sel_idx;
  logic             accept, start_refill, issue, sel_err, out_load;

  // Refill scanner.
  rdcp_refill_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .clr    (start_refill),
    .adv    (state_r == S_REFILL),
    .filter (filter_r),
    .scan   (scan)
  );

  // Handshake and control decode.
  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign start_refill = accept && (count_r == '0);
  assign issue        = (accept && (count_r != '0)) || (state_r == S_ISSUE);
  assign sel_idx      = (state_r == S_ISSUE) ? idx_r : in_ch.random_index;
  assign sel_err      = !(sel_idx < count_r);
  assign out_load     = (state_r == S_DRAW) && (!out_valid_r || out_ch.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_REFILL: begin
        if (scan.last) begin
          state_nxt = pending_r ? S_ISSUE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_refill) begin
          state_nxt = S_REFILL;
        end else if (accept) begin
          state_nxt = S_DRAW;
        end
      end
      S_ISSUE: state_nxt = S_DRAW;
      S_DRAW: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_REFILL;
    endcase
  end

  // Control registers: state, pool count, refill fill pointer and config.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_REFILL;
      reject_r  <= 1'b1;
      filter_r  <= 1'b1;
      pending_r <= 1'b0;
      count_r   <= '0;
      fill_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        reject_r <= cfg_wdata;
      end
      if (start_refill) begin
        filter_r  <= reject_r;
        pending_r <= 1'b1;
        fill_r    <= '0;
      end else if (state_r == S_REFILL) begin
        fill_r <= fill_r + rdcp_pkg::field_t'(scan.keep);
        if (scan.last) begin
          count_r   <= fill_r + rdcp_pkg::field_t'(scan.keep);
          pending_r <= 1'b0;
        end
      end
      if (out_load && !err_r) begin
        count_r <= count_r - rdcp_pkg::field_t'(1);
      end
    end
  end

  // Draw operands: index on request accept, error flag when reads are issued.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= in_ch.random_index;
    end
    if (issue) begin
      err_r <= sel_err;
    end
  end

  // Memory port selection: refill writes packed codes, a draw fills the hole.
  assign rd_a_en   = issue && !sel_err;
  assign rd_a_addr = sel_idx;
  assign rd_b_en   = issue;
  assign rd_b_addr = count_r - rdcp_pkg::field_t'(1);
  assign wr_en     = ((state_r == S_REFILL) && scan.keep) || (out_load && !err_r);
  assign wr_addr   = (state_r == S_REFILL) ? fill_r : idx_r;
  assign wr_data   = (state_r == S_REFILL) ? scan.code : rd_b_q;

  // Pool memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_a_en) begin
      rd_a_q <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_q <= mem[rd_b_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r      <= err_r ? '0 : rd_a_q;
      out_remaining_r <= err_r ? count_r : count_r - rdcp_pkg::field_t'(1);
      out_status_r    <= err_r ? rdcp_pkg::STATUS_ERR : rdcp_pkg::STATUS_OK;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.drawn_code = out_code_r;
  assign out_ch.remaining  = out_remaining_r;
  assign out_ch.status     = out_status_r;

  // The pool never grows past the number of codes.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rdcp_pkg::POOL_MAX)
    else $error("pool count exceeds code count");

  // A successful draw shrinks the pool by exactly one.
  a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !err_r) |=> (count_r == $past(count_r) - rdcp_pkg::field_t'(1)))
    else $error("pool count did not drop after a draw");

  // A rejected index leaves the pool count alone.
  a_err_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && err_r) |=> $stable(count_r))
    else $error("pool count changed on a rejected index");

  // Error results always carry a zero code.
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == rdcp_pkg::STATUS_ERR)) |-> (out_code_r == '0))
    else $error("error result carries a nonzero code");

  // A draw finds a nonempty pool once its reads are issued.
  a_issue_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (count_r != '0))
    else $error("draw issued on an empty pool");

endmodule
